@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL file indexed_array_list.
// Each check is sampled on the rising clock edge and switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) \
        (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk_s, rstn_s, prop, msg)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

@@ sv/ial_pkg.sv @@
`default_nettype none

package ial_pkg;

    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int POS_W   = 6;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Per-cell operations.
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [31:0]       data_in;
    } req_t;

    typedef struct packed {
        logic [31:0]        data_out;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // Command broadcast along the row of cells.
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  position;
        logic [DATA_W-1:0] word;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ sv/ial_cell.sv @@
`default_nettype none

module ial_cell
    import ial_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  idx,
    input  logic [DATA_W-1:0] from_lower,
    input  logic [DATA_W-1:0] from_upper,
    output logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] tap
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              hit;
    logic              above;

    assign hit   = (idx == cmd.position);
    assign above = (idx > cmd.position);

    // An insert moves entries above the position up and drops the new word in;
    // a delete pulls every entry from the position onwards down by one.
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CELL_INS:
            begin
                if (above)
                begin
                    value_next = from_lower;
                end
                else if (hit)
                begin
                    value_next = cmd.word;
                end
            end
            CELL_DEL:
            begin
                if (above || hit)
                begin
                    value_next = from_upper;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = hit ? value_reg : '0;

endmodule

`default_nettype wire

@@ sv/indexed_array_list.sv @@
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+---------------------------------
// request   | in        | start high, busy low   | req    (kind, position, data_in)
// response  | out       | done, one cycle only   | result (data_out, status, count)
//
// One request is taken in every clock cycle; busy stays low at all times.
// The response to a request accepted at one edge is presented for the single
// cycle that follows it, so the rate is one per cycle.
// That rate is set by the row of cells: every cell moves in the same edge.
// Reset clears the entry count and the response strobe; the entries themselves
// are not cleared and are only ever read below the count.
// The receiver cannot stall, so no response is ever held back.

module indexed_array_list
    import ial_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t result
);

`include "assert_macros.svh"

    logic [COUNT_W-1:0] fill_count_reg;
    logic [COUNT_W-1:0] fill_count_next;
    logic               done_reg;
    logic               done_next;
    rsp_t               result_reg;
    rsp_t               result_next;

    cell_cmd_t          cmd;
    logic [COUNT_W-1:0] pos_ext;
    logic [DATA_W-1:0]  sel_data;
    logic               accept;

    logic [DATA_W-1:0]  cell_value [DEPTH];
    logic [DATA_W-1:0]  cell_tap   [DEPTH];

    // The list can always take a new request in the next cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_ext = COUNT_W'(req.position);

    // Every cell offers its word only when it sits at the addressed position,
    // so an OR over the row gives the word at that position.
    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            sel_data = sel_data | cell_tap[i];
        end
    end

    // Request decoding: status, data returned, new length and the command
    // that is broadcast to the row of cells.
    always_comb
    begin
        cmd.op          = CELL_HOLD;
        cmd.position    = IDX_W'(req.position);
        cmd.word        = DATA_W'(req.data_in);
        fill_count_next = fill_count_reg;
        result_next     = '0;
        result_next.status = ST_OK;
        case (req.kind)
            KIND_INSERT:
            begin
                if (fill_count_reg == COUNT_W'(DEPTH))
                begin
                    result_next.status = ST_FULL;
                end
                else if (pos_ext > fill_count_reg)
                begin
                    result_next.status = ST_RANGE;
                end
                else
                begin
                    cmd.op          = CELL_INS;
                    fill_count_next = fill_count_reg + COUNT_W'(1);
                end
            end
            KIND_DELETE:
            begin
                if (pos_ext >= fill_count_reg)
                begin
                    result_next.status = ST_RANGE;
                end
                else
                begin
                    cmd.op               = CELL_DEL;
                    result_next.data_out = 32'(sel_data);
                    fill_count_next      = fill_count_reg - COUNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_ext >= fill_count_reg)
                begin
                    result_next.status = ST_RANGE;
                end
                else
                begin
                    result_next.data_out = 32'(sel_data);
                end
            end
            default:
            begin
                result_next.status = ST_RANGE;
            end
        endcase
        // Without a transfer the row holds and the length stays.
        if (!accept)
        begin
            cmd.op          = CELL_HOLD;
            fill_count_next = fill_count_reg;
        end
        result_next.count = fill_count_next;
        done_next         = accept;
    end

    // The row of cells; each end cell feeds its own word back to itself on
    // the side with no neighbour; cell 0 never takes it, the last cell does on a delete.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = cell_value[i];
        end
        else
        begin : g_lower
            assign lower = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_value[i];
        end
        else
        begin : g_upper
            assign upper = cell_value[i+1];
        end

        ial_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .from_lower (lower),
            .from_upper (upper),
            .value      (cell_value[i]),
            .tap        (cell_tap[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLKD(a_count_bound, clk, rst_n,
        fill_count_reg <= COUNT_W'(DEPTH), "length exceeds capacity")
    `ASSERT_NEXT(a_one_response, clk, rst_n,
        accept, done, "accepted request produced no response")
    `ASSERT_NEXT(a_length_moves_with_transfer, clk, rst_n,
        !accept, fill_count_reg == $past(fill_count_reg), "length changed without a transfer")
    `ASSERT_CLKD(a_full_only_at_capacity, clk, rst_n,
        !(done && result.status == ST_FULL) || (result.count == COUNT_W'(DEPTH)),
        "full status below capacity")
    `ASSERT_CLKD(a_error_data_zero, clk, rst_n,
        !(done && result.status != ST_OK) || (result.data_out == '0),
        "error response carries data")

endmodule

`default_nettype wire
